[rtl/fcsc_pkg.sv]
// Shared types, constants and the CRC byte step for the flash CRC scan controller.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package fcsc_pkg;

	localparam int FLASH_BYTES_DEF = 16384;
	localparam int CFG_ADDR_W = 3;
	localparam int SEC_W = 17;

	localparam logic [15:0] CRC_INIT = 16'hffff;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam int CA_ENABLE_BIT = 0;
	localparam int CA_NMIEN_BIT = 1;
	localparam int CA_RESET_BIT = 7;

	localparam logic [1:0] SEL_APP = 2'd1;
	localparam logic [1:0] SEL_BOOT = 2'd2;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_CTRLA = 2'd1,
		KIND_CTRLB = 2'd2,
		KIND_READ = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [13:0] flash_address;
		logic [7:0] write_value;
	} in_item_t;

	typedef struct packed {
		logic status_ok;
		logic [7:0] control_a_value;
		logic [7:0] control_b_value;
		logic nmi_raise;
		logic lock_state;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_READ,
		OP_LOAD,
		OP_CB,
		OP_CA_CLEAR,
		OP_CA_STORE,
		OP_CA_SCAN,
		OP_CA_SHORT
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK
	} fsm_t;

	typedef struct packed {
		op_t op;
		logic rd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic lock;
		logic short_sec;
		logic at_last;
	} sts_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/fcsc_regs.sv]
// Configuration register file holding the application and boot section fuses.
// Depends on fcsc_pkg for the address width.
`default_nettype none

module fcsc_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [fcsc_pkg::CFG_ADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic [7:0] app_fuse,
	output logic [7:0] boot_fuse
);
	import fcsc_pkg::*;

	logic [7:0] app_q;
	logic [7:0] boot_q;
	logic wr_en;

	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_q <= '0;
			boot_q <= '0;
		end else if (wr_en) begin
			if (paddr[2]) begin
				boot_q <= pwdata[7:0];
			end else begin
				app_q <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2]) begin
			prdata[7:0] = boot_q;
		end else begin
			prdata[7:0] = app_q;
		end
	end

	assign app_fuse = app_q;
	assign boot_fuse = boot_q;

endmodule

`default_nettype wire

[rtl/fcsc_ctrl.sv]
// Controller state machine: decodes items and sequences the scan reads.
// Depends on fcsc_pkg for the command, status and state types.
`default_nettype none

module fcsc_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire fcsc_pkg::in_item_t item,
	input wire fcsc_pkg::sts_t sts,
	output fcsc_pkg::cmd_t cmd,
	output logic busy
);
	import fcsc_pkg::*;

	fsm_t state_q;
	fsm_t state_nxt;
	op_t dec_op;

	always_comb begin
		dec_op = OP_READ;
		unique case (item.kind)
			KIND_LOAD: dec_op = OP_LOAD;
			KIND_CTRLB: dec_op = OP_CB;
			KIND_READ: dec_op = OP_READ;
			KIND_CTRLA: begin
				priority if (sts.lock) begin
					dec_op = OP_READ;
				end else if (item.write_value[CA_RESET_BIT]) begin
					dec_op = OP_CA_CLEAR;
				end else if (!item.write_value[CA_ENABLE_BIT]) begin
					dec_op = OP_CA_STORE;
				end else if (sts.short_sec) begin
					dec_op = OP_CA_SHORT;
				end else begin
					dec_op = OP_CA_SCAN;
				end
			end
			default: dec_op = OP_READ;
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (start && dec_op == OP_CA_SCAN) state_nxt = ST_SCAN;
			ST_SCAN: if (sts.at_last) state_nxt = ST_CHECK;
			ST_CHECK: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_IDLE;
		cmd.rd = 1'b0;
		cmd.finish = 1'b0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) cmd.op = dec_op;
			end
			ST_SCAN: cmd.rd = 1'b1;
			ST_CHECK: cmd.finish = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/fcsc_datapath.sv]
// Datapath: flash memory, control and status registers, section end and CRC unit.
// Depends on fcsc_pkg; driven by commands from fcsc_ctrl.
`default_nettype none

module fcsc_datapath #(
	parameter int FLASH_BYTES = fcsc_pkg::FLASH_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire fcsc_pkg::in_item_t item,
	input wire logic [7:0] app_fuse,
	input wire logic [7:0] boot_fuse,
	input wire fcsc_pkg::cmd_t cmd,
	output fcsc_pkg::sts_t sts,
	output fcsc_pkg::out_item_t result,
	output logic done
);
	import fcsc_pkg::*;

	localparam int AW = $clog2(FLASH_BYTES);
	localparam logic [SEC_W-1:0] LAST_MAX = SEC_W'(FLASH_BYTES - 1);

	logic [7:0] mem [FLASH_BYTES];

	logic [7:0] ctrla_q;
	logic [7:0] ctrlb_q;
	logic status_q;
	logic lock_q;
	logic nmi_q;
	logic done_q;

	logic [AW-1:0] cnt_q;
	logic [AW-1:0] last_q;
	logic [AW-1:0] last_m1_q;
	logic [AW-1:0] idx_s1;
	logic rd_s1;
	logic [7:0] rdata_s1;
	logic [15:0] crc_q;
	logic [7:0] hi_q;

	logic [7:0] fuse;
	logic [SEC_W-1:0] sec_raw;
	logic [SEC_W-1:0] sec_last;
	logic [SEC_W-1:0] addr_ext;
	logic load_ok;
	logic match;
	logic accepted;

	always_comb begin
		fuse = 8'd0;
		if (ctrlb_q[1:0] == SEL_APP) begin
			fuse = app_fuse;
		end else if (ctrlb_q[1:0] == SEL_BOOT) begin
			fuse = boot_fuse;
		end
		sec_raw = {1'b0, fuse, 8'h00} - SEC_W'(1);
		if (fuse == 8'd0 || sec_raw > LAST_MAX) begin
			sec_last = LAST_MAX;
		end else begin
			sec_last = sec_raw;
		end
	end

	assign addr_ext = SEC_W'(item.flash_address);
	assign load_ok = (cmd.op == OP_LOAD) && (addr_ext < SEC_W'(FLASH_BYTES));
	assign match = (crc_q == {hi_q, rdata_s1});
	assign accepted = (cmd.op != OP_IDLE) && (cmd.op != OP_CA_SCAN);

	always_ff @(posedge clk) begin
		if (load_ok) begin
			mem[addr_ext[AW-1:0]] <= item.write_value;
		end
		if (cmd.rd) begin
			rdata_s1 <= mem[cnt_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CA_SCAN) begin
			cnt_q <= '0;
			last_q <= sec_last[AW-1:0];
			last_m1_q <= sec_last[AW-1:0] - AW'(1);
			crc_q <= CRC_INIT;
		end else begin
			if (cmd.rd) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (rd_s1 && idx_s1 < last_m1_q) begin
				crc_q <= crc_byte(crc_q, rdata_s1);
			end
		end
		if (rd_s1 && idx_s1 == last_m1_q) begin
			hi_q <= rdata_s1;
		end
		idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrla_q <= '0;
			ctrlb_q <= '0;
			status_q <= 1'b0;
			lock_q <= 1'b0;
			nmi_q <= 1'b0;
			done_q <= 1'b0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
			done_q <= accepted || cmd.finish;
			unique case (cmd.op)
				OP_CB: ctrlb_q <= item.write_value;
				OP_CA_CLEAR: begin
					ctrla_q <= '0;
					status_q <= 1'b0;
				end
				OP_CA_STORE: begin
					ctrla_q <= item.write_value;
					status_q <= 1'b0;
				end
				OP_CA_SCAN: begin
					ctrla_q <= item.write_value;
					if (item.write_value[CA_NMIEN_BIT]) lock_q <= 1'b1;
				end
				OP_CA_SHORT: begin
					ctrla_q <= item.write_value;
					status_q <= 1'b0;
					if (item.write_value[CA_NMIEN_BIT]) lock_q <= 1'b1;
				end
				default: ;
			endcase
			if (cmd.finish) begin
				status_q <= match;
				nmi_q <= !match && ctrla_q[CA_NMIEN_BIT];
			end else begin
				nmi_q <= (cmd.op == OP_CA_SHORT) && item.write_value[CA_NMIEN_BIT];
			end
		end
	end

	assign sts.lock = lock_q;
	assign sts.short_sec = (sec_last < SEC_W'(2));
	assign sts.at_last = (cnt_q == last_q);

	assign result.status_ok = status_q;
	assign result.control_a_value = ctrla_q;
	assign result.control_b_value = ctrlb_q;
	assign result.nmi_raise = nmi_q;
	assign result.lock_state = lock_q;
	assign done = done_q;

endmodule

`default_nettype wire

[rtl/flash_crc_scan_controller.sv]
// Flash CRC scan controller top level. A load, register write or read gives its result
// in the cycle after acceptance, and the next item may be accepted in the following cycle.
// A scanning CTRLA write keeps busy high while it reads the section, one flash read per cycle,
// and then does one compare, from which its result is registered.
// The receiver cannot stall; each result is shown for exactly one cycle with done high.
// Reset clears the control, status, lock and fuse registers; flash contents are not reset.
`default_nettype none

module flash_crc_scan_controller #(
	parameter int FLASH_BYTES = fcsc_pkg::FLASH_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire fcsc_pkg::in_item_t item,
	output logic done,
	output fcsc_pkg::out_item_t result,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [fcsc_pkg::CFG_ADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import fcsc_pkg::*;

	logic [7:0] app_fuse;
	logic [7:0] boot_fuse;
	cmd_t cmd;
	sts_t sts;

	fcsc_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.app_fuse(app_fuse),
		.boot_fuse(boot_fuse)
	);

	fcsc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.sts(sts),
		.cmd(cmd),
		.busy(busy)
	);

	fcsc_datapath #(
		.FLASH_BYTES(FLASH_BYTES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.app_fuse(app_fuse),
		.boot_fuse(boot_fuse),
		.cmd(cmd),
		.sts(sts),
		.result(result),
		.done(done)
	);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result beat while busy.");

	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result.lock_state |=> result.lock_state)
		else $error("Lock cleared without reset.");

	a_nmi_with_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result.nmi_raise |-> (done && result.lock_state && !result.status_ok))
		else $error("NMI raised outside a failing locked scan result.");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && cmd.finish) |=> (done && !busy))
		else $error("Scan compare did not produce a result beat.");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Testbench for the flash CRC scan controller: fills the whole flash, then runs directed and
// random command phases and checks every response beat against an in-line model.
// Depends on fcsc_pkg and flash_crc_scan_controller.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fcsc_pkg::*;

	localparam int FLASH_DEPTH = FLASH_BYTES_DEF;
	localparam int PAGE_SIZE = 256;
	localparam int CYCLE_LIMIT = 1500000000;
	localparam int MAX_REPORTS = 40;
	localparam logic [CFG_ADDR_W-1:0] REG_APP_END = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BOOT_END = 3'd4;
	localparam logic [7:0] EN_MASK = 8'(1 << CA_ENABLE_BIT);
	localparam logic [7:0] NMIEN_MASK = 8'(1 << CA_NMIEN_BIT);
	localparam logic [7:0] RESET_MASK = 8'(1 << CA_RESET_BIT);
	localparam logic [1:0] SEL_FULL = 2'd0;
	localparam logic [1:0] SEL_FULL_ALT = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t item = '0;
	logic done;
	out_item_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [7:0] flash_mem [FLASH_DEPTH];
	logic [7:0] plan_flash [FLASH_DEPTH];
	logic [7:0] ctrl_a_q;
	logic [7:0] ctrl_b_q;
	logic status_q;
	logic lock_q;
	logic [7:0] app_end_q;
	logic [7:0] boot_end_q;
	logic [7:0] plan_ctrl_b;

	in_item_t pending_items [$];
	out_item_t expected_responses [$];
	out_item_t want;
	int queued_count = 0;
	int errors = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	flash_crc_scan_controller u_dut (.*);

	always #5 clk = ~clk;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] section_crc(input bit planned, input int count);
		logic [15:0] c;
		c = CRC_INIT;
		for (int i = 0; i < count; i++) begin
			c = crc_update(c, planned ? plan_flash[i] : flash_mem[i]);
		end
		return c;
	endfunction

	function automatic int section_last(input logic [7:0] cb);
		int last;
		last = FLASH_DEPTH - 1;
		if (cb[1:0] == SEL_APP && app_end_q != 0) begin
			last = int'(app_end_q) * PAGE_SIZE - 1;
		end else if (cb[1:0] == SEL_BOOT && boot_end_q != 0) begin
			last = int'(boot_end_q) * PAGE_SIZE - 1;
		end
		if (last >= FLASH_DEPTH) begin
			last = FLASH_DEPTH - 1;
		end
		return last;
	endfunction

	function automatic logic scan_passes();
		int last;
		last = section_last(ctrl_b_q);
		if (last < 2) begin
			return 1'b0;
		end
		return section_crc(1'b0, last - 1) == {flash_mem[last - 1], flash_mem[last]};
	endfunction

	task automatic predict_response(input in_item_t cmd);
		out_item_t r;
		logic pass;
		r = '0;
		case (cmd.kind)
			KIND_LOAD: begin
				flash_mem[cmd.flash_address] = cmd.write_value;
			end
			KIND_CTRLA: begin
				if (!lock_q) begin
					if (cmd.write_value[CA_RESET_BIT]) begin
						ctrl_a_q = '0;
						status_q = 1'b0;
					end else begin
						ctrl_a_q = cmd.write_value;
						if (cmd.write_value[CA_ENABLE_BIT]) begin
							if (cmd.write_value[CA_NMIEN_BIT]) begin
								lock_q = 1'b1;
							end
							pass = scan_passes();
							status_q = pass;
							r.nmi_raise = !pass && cmd.write_value[CA_NMIEN_BIT];
						end else begin
							status_q = 1'b0;
						end
					end
				end
			end
			KIND_CTRLB: begin
				ctrl_b_q = cmd.write_value;
			end
			default: begin
			end
		endcase
		r.status_ok = status_q;
		r.control_a_value = ctrl_a_q;
		r.control_b_value = ctrl_b_q;
		r.lock_state = lock_q;
		expected_responses.push_back(r);
	endtask

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("[cycle %0d] mismatch: %s", cycle_count, what);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] wanted);
		if (got !== wanted) begin
			report_mismatch($sformatf("%s got %0h, wanted %0h", name, got, wanted));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_response(item);
			end
			if (!start || !busy) begin
				if (idle_cycles > 0) begin
					idle_cycles--;
					start <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item <= pending_items.pop_front();
					start <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						idle_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_responses.size() == 0) begin
				report_mismatch("response beat with nothing expected");
			end else begin
				want = expected_responses.pop_front();
				check_field("status_ok", 8'(result.status_ok), 8'(want.status_ok));
				check_field("control_a_value", result.control_a_value, want.control_a_value);
				check_field("control_b_value", result.control_b_value, want.control_b_value);
				check_field("nmi_raise", 8'(result.nmi_raise), 8'(want.nmi_raise));
				check_field("lock_state", 8'(result.lock_state), 8'(want.lock_state));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic queue_item(input kind_t cmd_kind, input logic [13:0] addr,
			input logic [7:0] value);
		in_item_t cmd;
		cmd.kind = cmd_kind;
		cmd.flash_address = addr;
		cmd.write_value = value;
		pending_items.push_back(cmd);
		queued_count++;
		if (cmd_kind == KIND_LOAD) begin
			plan_flash[addr] = value;
		end
		if (cmd_kind == KIND_CTRLB) begin
			plan_ctrl_b = value;
		end
	endtask

	// Loads the two stored CRC bytes at the end of the section that CTRLB will select, corrupted unless good is set.
	task automatic queue_crc_tail(input bit good);
		int last;
		logic [15:0] sum;
		last = section_last(plan_ctrl_b);
		sum = section_crc(1'b1, last - 1);
		if (!good) begin
			sum ^= 16'($urandom_range(1, 16'hffff));
		end
		queue_item(KIND_LOAD, 14'(last - 1), sum[15:8]);
		queue_item(KIND_LOAD, 14'(last), sum[7:0]);
	endtask

	task automatic queue_scan_sequence();
		logic [7:0] cb;
		logic [7:0] ca;
		if ($urandom_range(0, 2) != 0) begin
			cb = 8'($urandom);
			if ($urandom_range(0, 9) == 0) begin
				cb[1:0] = $urandom_range(0, 1) ? SEL_FULL : SEL_FULL_ALT;
			end else begin
				cb[1:0] = $urandom_range(0, 1) ? SEL_APP : SEL_BOOT;
			end
			queue_item(KIND_CTRLB, 14'($urandom), cb);
		end
		if ($urandom_range(0, 3) == 0) begin
			queue_item(KIND_LOAD, 14'($urandom), 8'($urandom));
		end
		queue_crc_tail($urandom_range(0, 7) != 0);
		ca = 8'($urandom);
		ca[CA_ENABLE_BIT] = 1'b1;
		ca[CA_NMIEN_BIT] = 1'b0;
		ca[CA_RESET_BIT] = 1'b0;
		queue_item(KIND_CTRLA, 14'($urandom), ca);
	endtask

	task automatic queue_noise(input bit allow_lock);
		logic [7:0] v;
		v = 8'($urandom);
		case ($urandom_range(0, 3))
			0: begin
				queue_item(KIND_LOAD, 14'($urandom), v);
			end
			1: begin
				if (!allow_lock && v[CA_ENABLE_BIT] && !v[CA_RESET_BIT]) begin
					v[CA_NMIEN_BIT] = 1'b0;
				end
				queue_item(KIND_CTRLA, 14'($urandom), v);
			end
			2: begin
				queue_item(KIND_CTRLB, 14'($urandom), v);
			end
			default: begin
				queue_item(KIND_READ, 14'($urandom), v);
			end
		endcase
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_items.size() != 0 || start || expected_responses.size() != 0);
	endtask

	task automatic write_fuse(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_APP_END) begin
			app_end_q = value;
		end else begin
			boot_end_q = value;
		end
	endtask

	task automatic set_fuses(input logic [7:0] app_end, input logic [7:0] boot_end);
		write_fuse(REG_APP_END, app_end);
		write_fuse(REG_BOOT_END, boot_end);
	endtask

	task automatic run_random_phase(input int count);
		int target;
		target = queued_count + count;
		while (queued_count < target) begin
			if ($urandom_range(0, 9) < 6) begin
				queue_scan_sequence();
			end else begin
				queue_noise(1'b0);
			end
		end
		drain();
	endtask

	initial begin
		ctrl_a_q = '0;
		ctrl_b_q = '0;
		status_q = 1'b0;
		lock_q = 1'b0;
		app_end_q = '0;
		boot_end_q = '0;
		plan_ctrl_b = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Every flash byte is written before the first scan.
		for (int a = 0; a < FLASH_DEPTH; a++) begin
			queue_item(KIND_LOAD, 14'(a), 8'($urandom));
		end

		queue_item(KIND_LOAD, 14'd0, 8'h00);
		queue_item(KIND_LOAD, 14'h3fff, 8'hff);
		queue_item(KIND_READ, 14'h3fff, 8'hff);
		queue_item(KIND_CTRLB, 14'd0, {6'd0, SEL_APP});
		queue_crc_tail(1'b1);
		queue_item(KIND_CTRLA, 14'd0, EN_MASK);
		queue_item(KIND_CTRLA, 14'd0, 8'h00);
		queue_item(KIND_CTRLA, 14'h3fff, RESET_MASK | NMIEN_MASK | EN_MASK);
		queue_item(KIND_CTRLB, 14'h3fff, {6'h3f, SEL_BOOT});
		queue_item(KIND_CTRLA, 14'd0, 8'h7c | EN_MASK);
		queue_item(KIND_LOAD, 14'd5, ~plan_flash[5]);
		queue_item(KIND_CTRLA, 14'd0, EN_MASK);
		queue_item(KIND_CTRLA, 14'd0, 8'h7c | NMIEN_MASK);
		queue_item(KIND_CTRLB, 14'd0, {6'd0, SEL_FULL_ALT});
		queue_crc_tail(1'b1);
		queue_item(KIND_CTRLA, 14'd0, EN_MASK);
		queue_item(KIND_CTRLB, 14'd0, 8'h00);
		queue_item(KIND_READ, 14'd0, 8'h00);
		drain();

		set_fuses(8'd1, 8'd255);
		queue_item(KIND_CTRLB, 14'd0, {6'd0, SEL_APP});
		queue_crc_tail(1'b1);
		queue_item(KIND_CTRLA, 14'd0, EN_MASK);
		queue_item(KIND_CTRLB, 14'd0, {6'd0, SEL_BOOT});
		queue_crc_tail(1'b1);
		queue_item(KIND_CTRLA, 14'd0, EN_MASK);
		run_random_phase(25);

		set_fuses(8'd255, 8'd1);
		run_random_phase(25);
		set_fuses(8'd2, 8'd64);
		run_random_phase(25);
		set_fuses(8'd0, 8'd4);
		run_random_phase(25);

		// A failing scan with NMIEN locks CTRLA for the rest of the run.
		queue_item(KIND_CTRLB, 14'd0, {6'd0, SEL_BOOT});
		queue_crc_tail(1'b0);
		queue_item(KIND_CTRLA, 14'd0, NMIEN_MASK | EN_MASK);
		queue_item(KIND_CTRLA, 14'd0, RESET_MASK);
		queue_item(KIND_CTRLA, 14'd0, EN_MASK);
		for (int n = 0; n < 15; n++) begin
			queue_noise(1'b1);
		end
		drain();

		repeat (32) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
